// ===== src/gbcg_pkg.sv =====
// gbcg_pkg: shared types and constants of the glyph band command generator.
// No dependencies; imported by the top level.
`default_nettype none

package gbcg_pkg;

  // Storage and field widths
  localparam int FONT_BYTES_DEF = 8192;
  localparam int LOAD_ADDR_W    = 13;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 8;
  localparam int STRIDE_W       = 9;   // wmax * bands + 1 <= 481
  localparam int OFFSET_W       = 9;   // 1 + wmax * band <= 421

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_CODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_CODE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_MAX    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_BANDS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAYOUT_MODE  = 3'd4;

  // Register reset values and limits
  localparam logic [7:0] FIRST_CODE_RST   = 8'd32;
  localparam logic [7:0] LAST_CODE_RST    = 8'd127;
  localparam logic [5:0] WIDTH_MAX_RST    = 6'd15;
  localparam logic [3:0] HEIGHT_BANDS_RST = 4'd2;
  localparam logic [5:0] WIDTH_MAX_LIMIT  = 6'd60;
  localparam logic [3:0] BANDS_LIMIT      = 4'd8;

  // Operation and layout codes
  localparam logic OP_LOAD       = 1'b0;
  localparam logic OP_DRAW       = 1'b1;
  localparam logic LAYOUT_TEXT   = 1'b0;
  localparam logic LAYOUT_BITMAP = 1'b1;

  // Display controller bytes
  localparam logic [7:0] CMD_PAGE        = 8'hB0;
  localparam logic [7:0] CMD_COL_UPPER   = 8'h10;
  localparam logic [7:0] LOW_NIBBLE      = 8'h0F;
  localparam logic [7:0] TEXT_SUBSTITUTE = 8'h2E;  // '.'
  localparam logic [7:0] BITMAP_SUBSTITUTE = 8'h00;

  typedef struct packed {
    logic                   operation;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic [7:0]             load_value;
    logic [7:0]             glyph_code;
    logic [3:0]             page_base;
    logic [7:0]             start_column;
    logic [2:0]             band_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
    logic [5:0] advance;
  } out_item_t;

  // Which of the three command bytes goes out next
  typedef enum logic [1:0] {
    CMD_SEL_PAGE  = 2'd0,
    CMD_SEL_UPPER = 2'd1,
    CMD_SEL_LOWER = 2'd2
  } cmd_sel_t;

endpackage

`default_nettype wire

// ===== src/gbcg_modadd.sv =====
// gbcg_modadd: shared modular adder, (a + b) with one conditional subtract of MODULUS.
// No dependencies; instantiated by the top level.
`default_nettype none

module gbcg_modadd #(
  parameter int MODULUS = 8192,
  parameter int W       = 14
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] result,
  output logic              wrapped
);

  localparam logic [W:0] MOD_C = (W+1)'(MODULUS);

  logic [W:0] sum;
  logic [W:0] diff;

  assign sum     = {1'b0, a} + {1'b0, b};
  assign diff    = sum - MOD_C;
  assign wrapped = (sum >= MOD_C);
  assign result  = wrapped ? diff[W-1:0] : sum[W-1:0];

endmodule

`default_nettype wire

// ===== src/gbcg_font_mem.sv =====
// gbcg_font_mem: byte-wide glyph memory, one write port and one registered read port.
// No dependencies; instantiated by the top level.
`default_nettype none

module gbcg_font_mem #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/glyph_band_command_generator.sv =====
// glyph_band_command_generator: top level, sequencer, config registers, output register.
// Depends on gbcg_pkg, gbcg_modadd and gbcg_font_mem.
`default_nettype none

// Renders one 8-pixel band of a glyph as a page-mode display byte stream. A
// load transaction writes one byte of glyph memory; a draw transaction emits
// the page command, the two column commands, width data bytes and a blank
// data byte (last=1), each tagged with advance = saturated width + 1. The block
// takes one transaction at a time and is not ready until it is done. All font
// address math (record base = index * stride, column stepping, load address
// wrap) runs through one shared modular adder, one operation per cycle, so
// addresses wrap modulo FONT_BYTES when FONT_BYTES is at least 241. A draw runs
// accept, setup, stride reduce, the bit-serial index * stride multiply (8 bits,
// double then add), band offset add and reduce, three command bytes, data bytes
// at one per cycle while the output is not stalled, and the blank. A band at or
// above the clamped band count returns to idle from setup with no output. A load
// wraps its address by one subtract of FONT_BYTES per cycle, then writes the byte.
// There is no clearing pass: glyph memory is undefined until loaded.
module glyph_band_command_generator
  import gbcg_pkg::*;
#(
  parameter int FONT_BYTES = FONT_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration write port
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_item,
  // output channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_item
);

  localparam int ADDR_W = $clog2(FONT_BYTES);
  // accumulator holds a load address or a value below 2*FONT_BYTES
  localparam int ACC_W  = (ADDR_W + 1 > LOAD_ADDR_W) ? ADDR_W + 1 : LOAD_ADDR_W;
  localparam logic [ACC_W-1:0] MOD_ACC = ACC_W'(FONT_BYTES);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_PREP  = 11'b000_0000_0010,
    ST_SRED  = 11'b000_0000_0100,
    ST_DBL   = 11'b000_0000_1000,
    ST_ADD   = 11'b000_0001_0000,
    ST_OFF   = 11'b000_0010_0000,
    ST_OFF2  = 11'b000_0100_0000,
    ST_CMD   = 11'b000_1000_0000,
    ST_DATA  = 11'b001_0000_0000,
    ST_BLANK = 11'b010_0000_0000,
    ST_LRED  = 11'b100_0000_0000
  } state_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [7:0] first_code;
  logic [7:0] last_code;
  logic [5:0] glyph_width_max;
  logic [3:0] height_bands;
  logic       layout_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_code      <= FIRST_CODE_RST;
      last_code       <= LAST_CODE_RST;
      glyph_width_max <= WIDTH_MAX_RST;
      height_bands    <= HEIGHT_BANDS_RST;
      layout_mode     <= LAYOUT_TEXT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FIRST_CODE:   first_code      <= cfg_data[7:0];
        CFG_LAST_CODE:    last_code       <= cfg_data[7:0];
        CFG_WIDTH_MAX:    glyph_width_max <= cfg_data[5:0];
        CFG_HEIGHT_BANDS: height_bands    <= cfg_data[3:0];
        CFG_LAYOUT_MODE:  layout_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamped geometry; user holds config stable while transaction is in flight; unchecked
  logic [5:0] wmax;
  logic [3:0] hb;

  always_comb begin
    if (glyph_width_max == 6'd0) begin
      wmax = 6'd1;
    end else if (glyph_width_max > WIDTH_MAX_LIMIT) begin
      wmax = WIDTH_MAX_LIMIT;
    end else begin
      wmax = glyph_width_max;
    end
    if (height_bands == 4'd0) begin
      hb = 4'd1;
    end else if (height_bands > BANDS_LIMIT) begin
      hb = BANDS_LIMIT;
    end else begin
      hb = height_bands;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  state_t                state, state_next;
  in_item_t              item_q;
  logic [ACC_W-1:0]      acc, acc_next;
  logic [ACC_W-1:0]      smod;       // stride mod FONT_BYTES
  logic [STRIDE_W-1:0]   stride_q;
  logic [OFFSET_W-1:0]   off_q;
  logic [7:0]            idx_q;
  logic [2:0]            bit_q;
  logic [5:0]            cnt_q;      // data bytes still to send
  logic [5:0]            adv_q;
  cmd_sel_t              cmd_sel;
  logic [7:0]            mem_q;

  // Record index with out-of-range substitution
  logic                  code_ok, sel_ok, band_ok;
  logic [7:0]            code_sub, code_sel, idx_calc;
  logic [STRIDE_W-1:0]   stride_calc;
  logic [OFFSET_W-1:0]   off_calc;
  logic [ACC_W-1:0]      step;
  logic [5:0]            width_sat;
  logic [3:0]            page_num;

  always_comb begin
    code_ok  = (item_q.glyph_code >= first_code) && (item_q.glyph_code <= last_code);
    code_sub = (layout_mode == LAYOUT_BITMAP) ? BITMAP_SUBSTITUTE : TEXT_SUBSTITUTE;
    code_sel = code_ok ? item_q.glyph_code : code_sub;
    sel_ok   = (code_sel >= first_code) && (code_sel <= last_code);
    idx_calc = sel_ok ? (code_sel - first_code) : 8'd0;
    band_ok  = ({1'b0, item_q.band_index} < hb);
    stride_calc = STRIDE_W'({3'b000, wmax} * {5'b00000, hb}) + STRIDE_W'(1);
    if (layout_mode == LAYOUT_BITMAP) begin
      off_calc = OFFSET_W'({3'b000, wmax} * {6'b000000, item_q.band_index})
               + OFFSET_W'(1);
      step     = ACC_W'(1);
    end else begin
      off_calc = OFFSET_W'(item_q.band_index) + OFFSET_W'(1);
      step     = ACC_W'(hb);
    end
    width_sat = (mem_q > {2'b00, wmax}) ? wmax : mem_q[5:0];
    page_num  = item_q.page_base + {1'b0, item_q.band_index};
  end

  // ---------------------------------------------------------------------
  // Shared modular adder
  // ---------------------------------------------------------------------
  logic [ACC_W-1:0] unit_a, unit_b, unit_r;
  logic             unit_wrap;

  always_comb begin
    unit_a = acc;
    unit_b = '0;
    unique case (state)
      ST_SRED: unit_a = ACC_W'(stride_q);
      ST_DBL:  unit_b = acc;
      ST_ADD:  unit_b = idx_q[bit_q] ? smod : '0;
      ST_OFF:  unit_b = ACC_W'(off_q);
      ST_DATA: unit_b = step;
      default: ;
    endcase
  end

  gbcg_modadd #(
    .MODULUS (FONT_BYTES),
    .W       (ACC_W)
  ) u_modadd (
    .a       (unit_a),
    .b       (unit_b),
    .result  (unit_r),
    .wrapped (unit_wrap)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic      can_load;   // output register free this cycle
  logic      push;
  out_item_t push_item;
  logic      mem_we;

  assign can_load = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    acc_next   = acc;
    push       = 1'b0;
    push_item  = '{out_byte: 8'h00, is_data: 1'b0, last: 1'b0, advance: adv_q};
    mem_we     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_item.operation == OP_LOAD) begin
            acc_next   = ACC_W'(in_item.load_address);
            state_next = ST_LRED;
          end else begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        acc_next   = '0;
        state_next = band_ok ? ST_SRED : ST_IDLE;
      end
      ST_SRED: state_next = ST_DBL;
      ST_DBL: begin
        acc_next   = unit_r;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        acc_next   = unit_r;
        state_next = (bit_q == 3'd0) ? ST_OFF : ST_DBL;
      end
      ST_OFF: begin
        acc_next   = unit_r;
        state_next = ST_OFF2;
      end
      ST_OFF2: begin
        acc_next   = unit_r;
        state_next = ST_CMD;
      end
      ST_CMD: begin
        if (can_load) begin
          push = 1'b1;
          unique case (cmd_sel)
            CMD_SEL_PAGE:  push_item.out_byte = CMD_PAGE | {4'h0, page_num};
            CMD_SEL_UPPER: push_item.out_byte = CMD_COL_UPPER
                                                | {4'h0, item_q.start_column[7:4]};
            CMD_SEL_LOWER: push_item.out_byte = item_q.start_column & LOW_NIBBLE;
            default:       push_item.out_byte = 8'h00;
          endcase
          if (cmd_sel == CMD_SEL_LOWER) begin
            state_next = (cnt_q == 6'd0) ? ST_BLANK : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (can_load) begin
          push               = 1'b1;
          push_item.out_byte = mem_q;
          push_item.is_data  = 1'b1;
          acc_next           = unit_r;
          if (cnt_q == 6'd1) begin
            state_next = ST_BLANK;
          end
        end
      end
      ST_BLANK: begin
        if (can_load) begin
          push              = 1'b1;
          push_item.is_data = 1'b1;
          push_item.last    = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      ST_LRED: begin
        // subtract until below FONT_BYTES, then write
        if (unit_wrap) begin
          acc_next = unit_r;
        end else begin
          mem_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (push) begin
      out_item <= push_item;
    end
    if (in_valid && in_ready) begin
      item_q <= in_item;
    end
    if (state == ST_PREP) begin
      stride_q <= stride_calc;
      off_q    <= off_calc;
      idx_q    <= idx_calc;
      bit_q    <= 3'd7;
      cmd_sel  <= CMD_SEL_PAGE;
    end
    if (state == ST_SRED) begin
      smod <= unit_r;
    end
    if (state == ST_ADD) begin
      bit_q <= bit_q - 3'd1;
    end
    // memory output holds the width byte in this state
    if (state == ST_OFF) begin
      cnt_q <= width_sat;
      adv_q <= width_sat + 6'd1;
    end
    if (state == ST_CMD && can_load) begin
      unique case (cmd_sel)
        CMD_SEL_PAGE:  cmd_sel <= CMD_SEL_UPPER;
        CMD_SEL_UPPER: cmd_sel <= CMD_SEL_LOWER;
        default:       cmd_sel <= CMD_SEL_PAGE;
      endcase
    end
    if (state == ST_DATA && can_load) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  // Read address follows the accumulator's next value, so mem_q holds the byte at
  // acc: one data byte per cycle in ST_DATA while the output is not stalled.
  gbcg_font_mem #(
    .DEPTH  (FONT_BYTES),
    .ADDR_W (ADDR_W)
  ) u_font_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (acc[ADDR_W-1:0]),
    .wdata (item_q.load_value),
    .raddr (acc_next[ADDR_W-1:0]),
    .rdata (mem_q)
  );

`ifndef ASSERT_OFF
  // data reads only come from fully wrapped addresses
  a_data_addr_wrapped: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DATA) |-> (acc < MOD_ACC))
    else $error("data address not reduced below FONT_BYTES");

  // the run always ends on a data byte
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last) |-> out_item.is_data)
    else $error("last flag on a command byte");

  // advance counts the blank column, so it is never zero
  a_advance_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.advance != 6'd0))
    else $error("advance of zero");

  // no byte is produced while a new transaction can be taken
  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !push)
    else $error("output pushed while idle");
`endif

endmodule

`default_nettype wire
